@@ hdl/quicksort_engine_core_defines.svh @@
// Assertion macros shared by the quicksort engine checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef QUICKSORT_ENGINE_CORE_DEFINES_SVH
`define QUICKSORT_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QSE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define QSE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/qse_pkg.sv @@
// Package for the quicksort engine: word types and sequencer states.
// No dependencies; imported by the core and by its checker.
package qse_pkg;

    typedef struct packed {
        logic signed [31:0] value;
        logic               is_last;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] sorted_value;
        logic               end_of_run;
    } t_out_word;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_POP,
        ST_POP_WAIT,
        ST_PIVOT,
        ST_LCHK,
        ST_LCMP,
        ST_RCMP,
        ST_SWAP2,
        ST_FIN_RD,
        ST_FIN_CMP,
        ST_FIN_SW2,
        ST_PUSH1,
        ST_PUSH2,
        ST_OUT_RD,
        ST_OUT_WAIT,
        ST_OUT_HOLD
    } t_state;

endpackage

@@ hdl/qse_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies; used for the element store and the range stack.
module qse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/quicksort_engine_core.sv @@
// Quicksort engine top level: loads a batch, sorts it in place, streams it out.
// Depends on qse_pkg and qse_ram.
// Load: one word per cycle. Sort: one shared signed comparator on a single-read
// element RAM; the sequencer steps through scan compares, swaps and subrange
// pops and pushes. Output: each word is read, registered and held until taken.
// Reset (synchronous, active low) clears the sequencer, element count, stack
// pointer and output valid; the RAMs are not cleared.
module quicksort_engine_core
    import qse_pkg::*;
#(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    localparam int IDX_W = $clog2(MAX_ELEMENTS);
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam int ENT_W = 2 * IDX_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ELEMENTS);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_sp;
    logic               r_out_valid;
    t_out_word          r_out_word;
    logic [IDX_W-1:0]   r_s, r_e, r_l, r_r;
    logic signed [31:0] r_pivot;
    logic signed [31:0] r_hold;

    logic               st_we;
    logic [IDX_W-1:0]   st_waddr, st_raddr;
    logic [31:0]        st_wdata;
    logic signed [31:0] st_rdata;
    logic               sk_we;
    logic [IDX_W-1:0]   sk_waddr, sk_raddr;
    logic [ENT_W-1:0]   sk_wdata, sk_rdata;

    logic               in_fire, load_room, rd_lt, pop_ok, is_end;
    logic [CNT_W-1:0]   load_n, l_ext, l_inc, s_inc, e_ext, r_ext;
    logic [IDX_W-1:0]   ent_s, ent_e;

    qse_ram #(.WIDTH(32), .DEPTH(MAX_ELEMENTS)) u_store (
        .i_clk  (i_clk),
        .i_we   (st_we),
        .i_waddr(st_waddr),
        .i_wdata(st_wdata),
        .i_raddr(st_raddr),
        .o_rdata(st_rdata)
    );

    qse_ram #(.WIDTH(ENT_W), .DEPTH(MAX_ELEMENTS)) u_stack (
        .i_clk  (i_clk),
        .i_we   (sk_we),
        .i_waddr(sk_waddr),
        .i_wdata(sk_wdata),
        .i_raddr(sk_raddr),
        .o_rdata(sk_rdata)
    );

    assign in_fire   = i_in_valid && o_in_ready;
    assign load_room = r_count < CNT_MAX;
    assign load_n    = load_room ? r_count + CNT_ONE : r_count;
    assign rd_lt     = st_rdata < r_pivot;
    assign l_ext     = CNT_W'(r_l);
    assign l_inc     = l_ext + CNT_ONE;
    assign s_inc     = CNT_W'(r_s) + CNT_ONE;
    assign e_ext     = CNT_W'(r_e);
    assign r_ext     = CNT_W'(r_r);
    assign ent_s     = sk_rdata[ENT_W-1:IDX_W];
    assign ent_e     = sk_rdata[IDX_W-1:0];
    assign pop_ok    = (ent_s < ent_e) && (CNT_W'(ent_e) < r_count);
    assign is_end    = l_inc == r_count;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (in_fire && i_in_word.is_last) begin
                    n_state = (load_n > CNT_ONE) ? ST_POP : ST_OUT_RD;
                end
            end
            ST_POP:      n_state = (r_sp == '0) ? ST_OUT_RD : ST_POP_WAIT;
            ST_POP_WAIT: n_state = pop_ok ? ST_PIVOT : ST_POP;
            ST_PIVOT:    n_state = ST_LCHK;
            ST_LCHK:     n_state = (r_l < r_r) ? ST_LCMP : ST_FIN_RD;
            ST_LCMP: begin
                if (rd_lt) begin
                    n_state = (l_inc < r_ext) ? ST_LCMP : ST_FIN_RD;
                end else begin
                    n_state = ST_RCMP;
                end
            end
            ST_RCMP: begin
                if (!rd_lt) begin
                    n_state = (l_inc < r_ext) ? ST_RCMP : ST_FIN_RD;
                end else begin
                    n_state = ST_SWAP2;
                end
            end
            ST_SWAP2:    n_state = ST_LCHK;
            ST_FIN_RD:   n_state = ST_FIN_CMP;
            ST_FIN_CMP:  n_state = rd_lt ? ST_PUSH1 : ST_FIN_SW2;
            ST_FIN_SW2:  n_state = ST_PUSH1;
            ST_PUSH1:    n_state = ST_PUSH2;
            ST_PUSH2:    n_state = ST_POP;
            ST_OUT_RD:   n_state = ST_OUT_WAIT;
            ST_OUT_WAIT: n_state = ST_OUT_HOLD;
            ST_OUT_HOLD: begin
                if (i_out_ready) begin
                    n_state = r_out_word.end_of_run ? ST_LOAD : ST_OUT_RD;
                end
            end
            default:     n_state = ST_LOAD;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        st_we      = 1'b0;
        st_waddr   = r_l;
        st_wdata   = r_hold;
        st_raddr   = r_l;
        sk_we      = 1'b0;
        sk_waddr   = r_sp[IDX_W-1:0];
        sk_wdata   = {r_s, r_e};
        sk_raddr   = r_sp[IDX_W-1:0];
        case (r_state)
            ST_LOAD: begin
                o_in_ready = 1'b1;
                st_we      = in_fire && load_room;
                st_waddr   = r_count[IDX_W-1:0];
                st_wdata   = i_in_word.value;
                sk_we      = in_fire && i_in_word.is_last && (load_n > CNT_ONE);
                sk_wdata   = {IDX_W'(0), IDX_W'(load_n - CNT_ONE)};
            end
            ST_POP:      sk_raddr = IDX_W'(r_sp - CNT_ONE);
            ST_POP_WAIT: st_raddr = ent_e;
            ST_LCHK:     st_raddr = r_l;
            ST_LCMP:     st_raddr = rd_lt ? IDX_W'(l_inc) : r_r;
            ST_RCMP: begin
                if (!rd_lt) begin
                    st_raddr = IDX_W'(r_ext - CNT_ONE);
                end else begin
                    st_we    = 1'b1;
                    st_waddr = r_l;
                    st_wdata = st_rdata;
                end
            end
            ST_SWAP2: begin
                st_we    = 1'b1;
                st_waddr = r_r;
                st_wdata = r_hold;
            end
            ST_FIN_RD:   st_raddr = r_l;
            ST_FIN_CMP: begin
                st_we    = !rd_lt;
                st_waddr = r_l;
                st_wdata = r_pivot;
            end
            ST_FIN_SW2: begin
                st_we    = 1'b1;
                st_waddr = r_e;
                st_wdata = r_hold;
            end
            ST_PUSH1: begin
                sk_we    = l_ext > s_inc;
                sk_wdata = {r_s, IDX_W'(l_ext - CNT_ONE)};
            end
            ST_PUSH2: begin
                sk_we    = e_ext > l_inc;
                sk_wdata = {IDX_W'(l_inc), r_e};
            end
            ST_OUT_RD:   st_raddr = r_l;
            default: begin
                st_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_LOAD: begin
                    if (in_fire) begin
                        r_count <= load_n;
                        if (i_in_word.is_last && (load_n > CNT_ONE)) begin
                            r_sp <= r_sp + CNT_ONE;
                        end
                    end
                end
                ST_POP: begin
                    if (r_sp != '0) begin
                        r_sp <= r_sp - CNT_ONE;
                    end
                end
                ST_PUSH1: begin
                    if (l_ext > s_inc) begin
                        r_sp <= r_sp + CNT_ONE;
                    end
                end
                ST_PUSH2: begin
                    if (e_ext > l_inc) begin
                        r_sp <= r_sp + CNT_ONE;
                    end
                end
                ST_OUT_WAIT: r_out_valid <= 1'b1;
                ST_OUT_HOLD: begin
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                        if (r_out_word.end_of_run) begin
                            r_count <= '0;
                        end
                    end
                end
                default: begin
                    r_out_valid <= r_out_valid;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_LOAD: begin
                if (in_fire && i_in_word.is_last) begin
                    r_l <= '0;
                end
            end
            ST_POP: begin
                if (r_sp == '0) begin
                    r_l <= '0;
                end
            end
            ST_POP_WAIT: begin
                r_s <= ent_s;
                r_e <= ent_e;
                r_l <= ent_s;
                r_r <= ent_e - IDX_W'(1);
            end
            ST_PIVOT: r_pivot <= st_rdata;
            ST_LCMP: begin
                if (rd_lt) begin
                    r_l <= IDX_W'(l_inc);
                end else begin
                    r_hold <= st_rdata;
                end
            end
            ST_RCMP: begin
                if (!rd_lt) begin
                    r_r <= r_r - IDX_W'(1);
                end
            end
            ST_FIN_CMP: begin
                if (rd_lt) begin
                    r_l <= IDX_W'(l_inc);
                end else begin
                    r_hold <= st_rdata;
                end
            end
            ST_OUT_WAIT: begin
                r_out_word.sorted_value <= st_rdata;
                r_out_word.end_of_run   <= is_end;
            end
            ST_OUT_HOLD: begin
                if (i_out_ready && !r_out_word.end_of_run) begin
                    r_l <= r_l + IDX_W'(1);
                end
            end
            default: begin
                r_hold <= r_hold;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

@@ hdl/qse_checker.sv @@
// Port-level checker for the quicksort engine, bound to the top level.
// Depends on qse_pkg and quicksort_engine_core_defines.svh.
`include "quicksort_engine_core_defines.svh"

module qse_checker
    import qse_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_word  i_in_word,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_word o_out_word
);

    `QSE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_word), "Output word changed while stalled.")
    `QSE_ASSERT_NOW(a_no_overlap, i_clk, i_rst_n, o_out_valid, !o_in_ready, "Input taken while a sorted word is pending.")
    `QSE_ASSERT_NEXT(a_load_ready, i_clk, i_rst_n, i_in_valid && o_in_ready && !i_in_word.is_last, o_in_ready, "Engine stopped loading before the last word.")
    `QSE_ASSERT_NEXT(a_run_done, i_clk, i_rst_n, o_out_valid && i_out_ready && o_out_word.end_of_run, o_in_ready && !o_out_valid, "Engine not ready after the end of a run.")

endmodule

bind quicksort_engine_core qse_checker u_qse_checker (.*);
